[sv/ble_private_address_resolver_unit_defines.svh]
// Assertion macros shared by the resolver checker.
// Depends on nothing; guarded against double inclusion.
`ifndef BLE_PRIVATE_ADDRESS_RESOLVER_UNIT_DEFINES_SVH
`define BLE_PRIVATE_ADDRESS_RESOLVER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BPAR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same check, also active during reset.
`define BPAR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[sv/bpar_pkg.sv]
// Shared types, constants and AES helper functions for the address resolver.
// No dependencies.
package bpar_pkg;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned AddrW = 48;

  typedef enum logic [1:0] {
    StatusMatch    = 2'd0,
    StatusBadType  = 2'd1,
    StatusZeroKey  = 2'd2,
    StatusMismatch = 2'd3
  } status_e;

  localparam logic [1:0] CfgIrkUpper = 2'd0;
  localparam logic [1:0] CfgIrkLower = 2'd1;

  localparam logic [1:0] AddrTypeMask = 2'b11;
  localparam logic [1:0] AddrTypeRpa  = 2'b01;

  // Pipeline sideband that travels with the AES state.
  typedef struct packed {
    logic       valid;
    logic       encrypt;
    logic [1:0] early_status;
    logic [23:0] hash;
  } side_t;

  // Result item: match flag and status code.
  typedef struct packed {
    logic       matched;
    logic [1:0] status;
  } result_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] Rcon [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of a 128-bit block; byte 0 is the most significant.
  function automatic logic [7:0] get_byte(logic [127:0] v, logic [3:0] i);
    logic [7:0] b;
    b = v[127 - 8*i -: 8];
    return b;
  endfunction

  function automatic logic [7:0] gf_double(logic [7:0] v);
    logic [7:0] r;
    r = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    return r;
  endfunction

  // Next round key from the current one.
  function automatic logic [127:0] next_key(logic [127:0] k, logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t = {Sbox[k[23:16]] ^ rc, Sbox[k[15:8]], Sbox[k[7:0]], Sbox[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes followed by ShiftRows.
  function automatic logic [127:0] sub_shift(logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*c + r) -: 8] = Sbox[get_byte(s, 4'((4*((c + r) % 4)) + r))];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4'(4*c));
      a1 = get_byte(s, 4'(4*c + 1));
      a2 = get_byte(s, 4'(4*c + 2));
      a3 = get_byte(s, 4'(4*c + 3));
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 32] = {a0 ^ al ^ gf_double(a0 ^ a1), a1 ^ al ^ gf_double(a1 ^ a2),
                             a2 ^ al ^ gf_double(a2 ^ a3), a3 ^ al ^ gf_double(a3 ^ a0)};
    end
    return t;
  endfunction
endpackage

[sv/bpar_if.sv]
// Valid/ready channel interface carrying a generic payload.
// No dependencies.
interface bpar_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/bpar_round_cell.sv]
// One AES round cell: round transform plus on-the-fly round key expansion.
// Depends on bpar_pkg.
module bpar_round_cell #(
  parameter int unsigned RoundIdx = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  bpar_pkg::side_t   side_i,
  input  logic [127:0]      state_i,
  input  logic [127:0]      key_i,
  output bpar_pkg::side_t   side_o,
  output logic [127:0]      state_o,
  output logic [127:0]      key_o
);
  localparam bit LastRound = (RoundIdx == bpar_pkg::NumRounds);

  logic [127:0] rkey_d, state_d, state_q, key_q, ss;
  bpar_pkg::side_t side_q;

  always_comb begin
    rkey_d  = bpar_pkg::next_key(key_i, bpar_pkg::Rcon[RoundIdx - 1]);
    ss      = bpar_pkg::sub_shift(state_i);
    state_d = (LastRound ? ss : bpar_pkg::mix_cols(ss)) ^ rkey_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q             <= state_d;
      key_q               <= rkey_d;
    end
  end

  assign side_o  = side_q;
  assign state_o = state_q;
  assign key_o   = key_q;
endmodule

[sv/ble_private_address_resolver_unit.sv]
// Resolvable private address checker: ten-cell AES-128 pipeline, one address per cycle unless stalled.
// Depends on bpar_pkg, bpar_if and bpar_round_cell.
//
// Each accepted address enters an input cell that applies the initial key
// whitening, then walks a row of ten round cells, each cell carrying both
// the state and its own expanded round key. The block takes one address
// every cycle; the whole row advances only when the output register is empty
// or being drained, so a stalled sink holds every item in place. Type and
// zero-key checks are decided at entry and ride alongside the data. Write the
// key only while no item is in flight.
module ble_private_address_resolver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  bpar_if.sink        addr_in,
  bpar_if.source      res_out
);
  localparam int unsigned N = bpar_pkg::NumRounds;

  logic [63:0] irk_upper_q, irk_lower_q;

  // Ignore writes to anything but the two key halves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irk_upper_q <= '0;
      irk_lower_q <= '0;
    end else if (cfg_we_i) begin
      if ({1'b0, cfg_idx_i} == bpar_pkg::CfgIrkUpper) irk_upper_q <= cfg_wdata_i;
      if ({1'b0, cfg_idx_i} == bpar_pkg::CfgIrkLower) irk_lower_q <= cfg_wdata_i;
    end
  end

  logic advance;
  logic [47:0] addr;
  assign addr = addr_in.data;
  // Advance when the output slot is free or being taken this cycle.
  assign advance = !res_out.valid || res_out.ready;
  assign addr_in.ready = advance;

  bpar_pkg::side_t side   [N+1];
  logic [127:0]    state  [N+1];
  logic [127:0]    key    [N+1];

  // Entry cell: classify the address and apply the first round key.
  bpar_pkg::side_t side_d, side0_q;
  logic [127:0] key_full, state0_q, key0_q;
  logic rpa, zero_key;

  always_comb begin
    key_full = {irk_upper_q, irk_lower_q};
    rpa      = (addr[47:46] & bpar_pkg::AddrTypeMask) == bpar_pkg::AddrTypeRpa;
    zero_key = (key_full == '0);
    side_d.valid        = addr_in.valid;
    side_d.encrypt      = rpa && !zero_key;
    side_d.early_status = !rpa ? bpar_pkg::StatusBadType : bpar_pkg::StatusZeroKey;
    side_d.hash         = addr[23:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side0_q <= '0;
    end else if (advance) begin
      side0_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      state0_q <= {104'd0, addr[47:24]} ^ key_full;
      key0_q   <= key_full;
    end
  end

  assign side[0]  = side0_q;
  assign state[0] = state0_q;
  assign key[0]   = key0_q;

  for (genvar g = 0; g < N; g++) begin : g_round
    bpar_round_cell #(.RoundIdx(g + 1)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .side_i  (side[g]),
      .state_i (state[g]),
      .key_i   (key[g]),
      .side_o  (side[g+1]),
      .state_o (state[g+1]),
      .key_o   (key[g+1])
    );
  end

  // Output register: compare the ciphertext tail against the hash.
  logic       out_valid_q;
  logic [1:0] status_d, status_q;

  always_comb begin
    if (!side[N].encrypt) begin
      status_d = side[N].early_status;
    end else if (state[N][23:0] == side[N].hash) begin
      status_d = bpar_pkg::StatusMatch;
    end else begin
      status_d = bpar_pkg::StatusMismatch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= side[N].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) status_q <= status_d;
  end

  assign res_out.valid        = out_valid_q;
  assign res_out.data.matched = (status_q == bpar_pkg::StatusMatch);
  assign res_out.data.status  = status_q;
endmodule

[sv/bpar_checker.sv]
// Port-level checks for the address resolver, bound to the top level.
// Depends on bpar_pkg and the defines header.
`include "ble_private_address_resolver_unit_defines.svh"
module bpar_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       matched,
  input logic [1:0] status
);
  `BPAR_ASSERT(a_match_flag, clk_i, rst_ni, out_valid |-> (matched == (status == bpar_pkg::StatusMatch)), "matched disagrees with status")
  `BPAR_ASSERT(a_stall_hold, clk_i, rst_ni, (out_valid && !out_ready) |=> (out_valid && $stable(status)), "stalled result changed")
  `BPAR_ASSERT(a_ready_free, clk_i, rst_ni, !out_valid |-> in_ready, "input blocked with empty output")
  `BPAR_ASSERT(a_in_hold, clk_i, rst_ni, (in_valid && !in_ready) |=> in_valid, "offered address withdrawn")
  `BPAR_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid, "result valid in reset")
endmodule

bind ble_private_address_resolver_unit bpar_checker u_bpar_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (addr_in.valid),
  .in_ready  (addr_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .matched   (res_out.data.matched),
  .status    (res_out.data.status)
);

[dv/ble_private_address_resolver_unit_tb.sv]
// Self-checking testbench for the BLE resolvable private address checker.
// Depends on bpar_pkg, bpar_if and the ble_private_address_resolver_unit RTL.
`timescale 1ns / 100ps

module ble_private_address_resolver_unit_tb;
  typedef bpar_pkg::result_t verdict_t;

  localparam int unsigned IdleWatchLimit = 3000;
  localparam int unsigned DrainCycles    = 24;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = bpar_pkg::CfgIrkUpper[0:0];
  logic [63:0] cfg_wdata_i = '0;

  bpar_if #(.payload_t(logic [bpar_pkg::AddrW-1:0])) addr_if ();
  bpar_if #(.payload_t(verdict_t))                   verdict_if ();

  ble_private_address_resolver_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .addr_in    (addr_if.sink),
    .res_out    (verdict_if.source)
  );

  always #6 clk_i = ~clk_i;

  // Key as the checker sees it; updated only while the pipeline is empty.
  logic [63:0] irk_hi = '0;
  logic [63:0] irk_lo = '0;

  logic [bpar_pkg::AddrW-1:0] pending_addrs[$];
  verdict_t         expected_verdicts[$];
  int unsigned      cycle_cnt = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      n_errors = 0;
  int unsigned      n_sent = 0;
  int unsigned      n_matched = 0;
  int unsigned      n_status[4] = '{0, 0, 0, 0};

  // ---------------------------------------------------------------------------
  // Behavioral AES-128 and the address verdict built on it
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] xtime(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes128_cipher(logic [127:0] key, logic [127:0] blk);
    logic [7:0]   st[16];
    logic [7:0]   tmp[16];
    logic [7:0]   rk[176];
    logic [7:0]   t0, t1, t2, t3, sw, a0, a1, a2, a3, al;
    logic [7:0]   rcon;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8*i -: 8];
      st[i] = blk[127 - 8*i -: 8];
    end
    rcon = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      t0 = rk[i-4]; t1 = rk[i-3]; t2 = rk[i-2]; t3 = rk[i-1];
      if (i % 16 == 0) begin
        sw = t0;
        t0 = bpar_pkg::Sbox[t1] ^ rcon;
        t1 = bpar_pkg::Sbox[t2];
        t2 = bpar_pkg::Sbox[t3];
        t3 = bpar_pkg::Sbox[sw];
        rcon = xtime(rcon);
      end
      rk[i]   = rk[i-16] ^ t0;
      rk[i+1] = rk[i-15] ^ t1;
      rk[i+2] = rk[i-14] ^ t2;
      rk[i+3] = rk[i-13] ^ t3;
    end
    for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      // substitute and rotate rows
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          tmp[4*c + r] = bpar_pkg::Sbox[st[4*((c + r) % 4) + r]];
      st = tmp;
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
          st[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
          st[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
          st[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[16*rnd + i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
    return res;
  endfunction

  // Hash that a resolvable address with this prand must carry under the key.
  function automatic logic [23:0] rpa_hash(logic [23:0] prand);
    logic [127:0] ct;
    ct = aes128_cipher({irk_hi, irk_lo}, {104'b0, prand});
    return ct[23:0];
  endfunction

  function automatic verdict_t resolve_address(logic [bpar_pkg::AddrW-1:0] addr);
    verdict_t v;
    if ((addr[47:46] & bpar_pkg::AddrTypeMask) != bpar_pkg::AddrTypeRpa)
      v.status = bpar_pkg::StatusBadType;
    else if (irk_hi == '0 && irk_lo == '0)        v.status = bpar_pkg::StatusZeroKey;
    else if (rpa_hash(addr[47:24]) == addr[23:0]) v.status = bpar_pkg::StatusMatch;
    else                                          v.status = bpar_pkg::StatusMismatch;
    v.matched = (v.status == bpar_pkg::StatusMatch);
    return v;
  endfunction

  // Half well-formed addresses that resolve; the rest near misses and noise.
  function automatic logic [bpar_pkg::AddrW-1:0] random_address();
    logic [bpar_pkg::AddrW-1:0] a;
    logic [23:0]      prand;
    int unsigned      pick;
    a = 48'({$urandom, $urandom});
    prand = {bpar_pkg::AddrTypeRpa, 22'($urandom)};
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      a = {prand, rpa_hash(prand)};
    end else if (pick < 7) begin
      a[47:46] = bpar_pkg::AddrTypeRpa;
    end else if (pick == 9) begin
      a = {prand, rpa_hash(prand) ^ (24'h1 << $urandom_range(0, 23))};
    end
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer pending addresses, idling now and then
  // ---------------------------------------------------------------------------
  initial begin
    addr_if.valid = 1'b0;
    addr_if.data  = '0;
    verdict_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    logic idle;
    idle = ($urandom_range(0, 99) < 10) && !(cycle_cnt inside {[400:900]});
    if (rst_ni) begin
      if (addr_if.valid && addr_if.ready) void'(pending_addrs.pop_front());
      if (addr_if.valid && !addr_if.ready) begin
        // hold the offered item until it is taken
      end else if (pending_addrs.size() > 0 && !idle) begin
        addr_if.valid <= 1'b1;
        addr_if.data  <= pending_addrs[0];
      end else begin
        addr_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off that backs up the pipeline
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == 320) hold_left <= 150;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      verdict_if.ready <= (hold_left <= 1) &&
                          ((cycle_cnt inside {[400:900]}) || $urandom_range(0, 99) >= 10);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input acceptance, check on output acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    verdict_t want;
    verdict_t got;
    if (rst_ni) begin
      if (addr_if.valid && addr_if.ready) begin
        expected_verdicts.push_back(resolve_address(addr_if.data));
        n_sent++;
      end
      if (verdict_if.valid && verdict_if.ready) begin
        got = verdict_if.data;
        if (expected_verdicts.size() == 0) begin
          $error("unexpected verdict: matched=%0d status=%0d", got.matched, got.status);
          n_errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got.matched !== want.matched) begin
            $error("matched: expected %0d, actual %0d", want.matched, got.matched);
            n_errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            n_errors++;
          end
          n_matched += want.matched;
          n_status[want.status]++;
        end
      end
      // watchdog: count cycles in which neither side moves an item
      if ((addr_if.valid && addr_if.ready) || (verdict_if.valid && verdict_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleWatchLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, then phases of addresses under different keys
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [0:0] idx, logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_key(logic [63:0] hi, logic [63:0] lo);
    write_reg(bpar_pkg::CfgIrkUpper[0:0], hi);
    write_reg(bpar_pkg::CfgIrkLower[0:0], lo);
    irk_hi = hi;
    irk_lo = lo;
  endtask

  // Wait for the pipeline to empty, then let in-flight cells settle.
  task automatic drain();
    while (pending_addrs.size() > 0 || expected_verdicts.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_directed();
    pending_addrs.push_back(48'h0);
    pending_addrs.push_back(48'hffff_ffff_ffff);
    pending_addrs.push_back(48'h4000_0000_0000);
    pending_addrs.push_back(48'h7fff_ffff_ffff);
    pending_addrs.push_back(48'h8000_0012_3456);
    pending_addrs.push_back(48'hc0ff_ee00_0001);
    pending_addrs.push_back({rpa_hash(24'h40_0000) == 24'h0 ? 24'h40_0001 : 24'h40_0000,
                             24'h0});
    pending_addrs.push_back({24'h7f_ffff, rpa_hash(24'h7f_ffff)});
    pending_addrs.push_back({24'h40_0000, rpa_hash(24'h40_0000)});
  endtask

  task automatic push_random(int unsigned n);
    repeat (n) pending_addrs.push_back(random_address());
  endtask

  initial begin
    #1;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero key: type check first, then the zero-key verdict
    push_directed();
    push_random(40);
    drain();

    load_key('1, '1);
    push_directed();
    push_random(100);
    drain();

    // fixed sample key
    load_key(64'hec02_3460_8ca3_5e0e, 64'hf12b_3c12_e8e8_b640);
    push_directed();
    push_random(260);
    drain();

    load_key('0, 64'h1);
    push_directed();
    push_random(100);
    drain();

    load_key(64'h8000_0000_0000_0000, '0);
    push_directed();
    push_random(100);
    drain();

    load_key({$urandom, $urandom}, {$urandom, $urandom});
    push_random(150);
    drain();

    // back to an all-zero key
    load_key('0, '0);
    push_directed();
    push_random(20);
    drain();

    $display("checked %0d addresses under 7 keys: %0d resolved, %0d wrong type,",
             n_sent, n_matched, n_status[bpar_pkg::StatusBadType]);
    $display("  %0d zero-key, %0d hash mismatch, with stalls and one long output hold-off",
             n_status[bpar_pkg::StatusZeroKey], n_status[bpar_pkg::StatusMismatch]);
    if (n_errors == 0 && expected_verdicts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
